@@ src/tbsp_pkg.sv @@
`default_nettype none
package tbsp_pkg;
  localparam int unsigned CoordW  = 16;
  localparam int unsigned SqW     = 2 * CoordW;
  localparam int unsigned SqrtStg = SqW / 2;
  localparam int unsigned DivStg  = SqW;
  localparam int unsigned DvsW    = CoordW + 1;
  localparam logic [CoordW-1:0] RadiusReset = CoordW'(13107);

  typedef logic [CoordW-1:0] coord_t;
  typedef logic [SqW-1:0]    sq_t;
endpackage
`default_nettype wire

@@ src/tbsp_if.sv @@
`default_nettype none
interface tbsp_in_if;
  logic                   valid;
  logic                   ready;
  logic signed [15:0]     point_x;
  logic signed [15:0]     point_y;
  modport source (output valid, point_x, point_y, input ready);
  modport sink   (input valid, point_x, point_y, output ready);
endinterface

interface tbsp_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] height_z;
  logic        on_hyperbola;
  logic        degenerate;
  modport source (output valid, height_z, on_hyperbola, degenerate, input ready);
  modport sink   (input valid, height_z, on_hyperbola, degenerate, output ready);
endinterface

interface tbsp_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] sphere_radius;
  modport source (output valid, sphere_radius, input ready);
  modport sink   (input valid, sphere_radius, output ready);
endinterface
`default_nettype wire

@@ src/trackball_sphere_projection_top.sv @@
`default_nettype none
// trackball projection: lifts a point (x, y), Q2.14, to a height z on a
// trackball of radius sphere_radius, or on the hyperbolic sheet where 2*(x^2+y^2) >= r^2.
// channels: in_s carries point_x/point_y, out_s carries height_z,
// on_hyperbola and degenerate, cfg_s writes sphere_radius (always ready).
// both data channels use valid/ready; a word moves when both are high.
// one word per cycle is accepted while out_s is not stalled. depth is set by
// the bit-per-stage square root (16 stages) followed by the bit-per-stage
// restoring divider (32 stages).
// the whole pipe advances together; when the receiver holds out_s.ready low
// with a word waiting, the pipe freezes and in_s.ready drops, so nothing is
// lost or repeated. empty slots in the pipe still fill while out is idle.
// reset clears all valid bits and loads the radius with 0.8 (13107).
// the radius must only be written while the pipe is empty.
module trackball_sphere_projection_top (
  input  wire logic clk,
  input  wire logic rst_n,
  tbsp_in_if.sink   in_s,
  tbsp_out_if.source out_s,
  tbsp_cfg_if.sink  cfg_s
);
  import tbsp_pkg::*;

  logic   en;
  coord_t rad_r;

  // stage 1: magnitudes
  logic   v1_r;
  coord_t ax_r, ay_r, rd1_r;
  // stage 2: squares
  logic   v2_r;
  sq_t    sx_r, sy_r, r2a_r;
  // stage 3: sum, region and root operand
  logic   v3_r, h3_r;
  sq_t    op3_r, r23_r;

  // square root stages
  logic v_sq_r   [SqrtStg+1];
  logic h_sq_r   [SqrtStg+1];
  sq_t  rem_sq_r [SqrtStg+1];
  sq_t  root_sq_r[SqrtStg+1];
  sq_t  r2_sq_r  [SqrtStg+1];

  // divider stages
  logic            v_dv_r  [DivStg+1];
  logic            h_dv_r  [DivStg+1];
  logic            dg_dv_r [DivStg+1];
  coord_t          z_dv_r  [DivStg+1];
  logic [DvsW:0]   rem_dv_r[DivStg+1];
  sq_t             wk_dv_r [DivStg+1];
  logic [DvsW-1:0] dvs_dv_r[DivStg+1];

  logic   ov_r, oh_r, od_r;
  coord_t oz_r;
  coord_t oz_nxt;

  assign en          = !ov_r || out_s.ready;
  assign in_s.ready  = en;
  assign cfg_s.ready = 1'b1;

  // radius register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rad_r <= RadiusReset;
    end else if (cfg_s.valid) begin
      rad_r <= cfg_s.sphere_radius;
    end
  end

  // front stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_s.valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ax_r  <= in_s.point_x[CoordW-1] ? coord_t'(-in_s.point_x) : coord_t'(in_s.point_x);
      ay_r  <= in_s.point_y[CoordW-1] ? coord_t'(-in_s.point_y) : coord_t'(in_s.point_y);
      rd1_r <= rad_r;
      sx_r  <= sq_t'(ax_r) * sq_t'(ax_r);
      sy_r  <= sq_t'(ay_r) * sq_t'(ay_r);
      r2a_r <= sq_t'(rd1_r) * sq_t'(rd1_r);
    end
  end

  // region test: inside when 2*s < r^2
  always_ff @(posedge clk) begin
    logic [SqW:0] s;
    logic         in_sph;
    s      = {1'b0, sx_r} + {1'b0, sy_r};
    in_sph = {s[SqW-1:0], 1'b0} < {1'b0, r2a_r};
    if (en) begin
      h3_r  <= !in_sph;
      op3_r <= in_sph ? (r2a_r - s[SqW-1:0]) : s[SqW-1:0];
      r23_r <= r2a_r;
    end
  end

  // square root entry
  assign v_sq_r[0]    = v3_r;
  assign h_sq_r[0]    = h3_r;
  assign rem_sq_r[0]  = op3_r;
  assign root_sq_r[0] = '0;
  assign r2_sq_r[0]   = r23_r;

  // one result bit per stage
  for (genvar k = 0; k < SqrtStg; k++) begin : g_sqrt
    localparam sq_t BitK = sq_t'(1) << (SqW - 2 - 2 * k);
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_sq_r[k+1] <= 1'b0;
      end else if (en) begin
        v_sq_r[k+1] <= v_sq_r[k];
      end
    end
    always_ff @(posedge clk) begin
      logic [SqW:0] trial;
      trial = {1'b0, root_sq_r[k]} + {1'b0, BitK};
      if (en) begin
        h_sq_r[k+1]  <= h_sq_r[k];
        r2_sq_r[k+1] <= r2_sq_r[k];
        if ({1'b0, rem_sq_r[k]} >= trial) begin
          rem_sq_r[k+1]  <= rem_sq_r[k] - trial[SqW-1:0];
          root_sq_r[k+1] <= (root_sq_r[k] >> 1) + BitK;
        end else begin
          rem_sq_r[k+1]  <= rem_sq_r[k];
          root_sq_r[k+1] <= root_sq_r[k] >> 1;
        end
      end
    end
  end

  // divider entry: divisor is 2*d, forced to one when d is zero
  logic   d_zero;
  coord_t d_root;
  assign d_root      = root_sq_r[SqrtStg][CoordW-1:0];
  assign d_zero      = (d_root == '0);
  assign v_dv_r[0]   = v_sq_r[SqrtStg];
  assign h_dv_r[0]   = h_sq_r[SqrtStg];
  assign dg_dv_r[0]  = h_sq_r[SqrtStg] && d_zero;
  assign z_dv_r[0]   = d_root;
  assign rem_dv_r[0] = '0;
  assign wk_dv_r[0]  = r2_sq_r[SqrtStg];
  assign dvs_dv_r[0] = d_zero ? DvsW'(1) : {d_root, 1'b0};

  // restoring divider, one quotient bit per stage
  for (genvar k = 0; k < DivStg; k++) begin : g_div
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_dv_r[k+1] <= 1'b0;
      end else if (en) begin
        v_dv_r[k+1] <= v_dv_r[k];
      end
    end
    always_ff @(posedge clk) begin
      logic [DvsW:0] sh;
      sh = {rem_dv_r[k][DvsW-1:0], wk_dv_r[k][SqW-1]};
      if (en) begin
        h_dv_r[k+1]   <= h_dv_r[k];
        dg_dv_r[k+1]  <= dg_dv_r[k];
        z_dv_r[k+1]   <= z_dv_r[k];
        dvs_dv_r[k+1] <= dvs_dv_r[k];
        if (sh >= {1'b0, dvs_dv_r[k]}) begin
          rem_dv_r[k+1] <= sh - {1'b0, dvs_dv_r[k]};
          wk_dv_r[k+1]  <= {wk_dv_r[k][SqW-2:0], 1'b1};
        end else begin
          rem_dv_r[k+1] <= sh;
          wk_dv_r[k+1]  <= {wk_dv_r[k][SqW-2:0], 1'b0};
        end
      end
    end
  end

  // result select with saturation
  always_comb begin
    if (!h_dv_r[DivStg]) begin
      oz_nxt = z_dv_r[DivStg];
    end else if (dg_dv_r[DivStg]) begin
      oz_nxt = '0;
    end else if (wk_dv_r[DivStg][SqW-1:CoordW] != '0) begin
      oz_nxt = '1;
    end else begin
      oz_nxt = wk_dv_r[DivStg][CoordW-1:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (en) begin
      ov_r <= v_dv_r[DivStg];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      oz_r <= oz_nxt;
      oh_r <= h_dv_r[DivStg];
      od_r <= dg_dv_r[DivStg];
    end
  end

  assign out_s.valid        = ov_r;
  assign out_s.height_z     = oz_r;
  assign out_s.on_hyperbola = oh_r;
  assign out_s.degenerate   = od_r;
endmodule
`default_nettype wire

@@ src/tbsp_check.sv @@
`default_nettype none
module tbsp_check (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [15:0] out_height_z,
  input wire logic        out_on_hyperbola,
  input wire logic        out_degenerate
);
  // a stalled word keeps its payload
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_height_z)
      && $stable(out_on_hyperbola) && $stable(out_degenerate))
    else $error("output word changed while stalled");

  // degenerate only on the sheet, with zero height
  a_degen: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_degenerate |-> out_on_hyperbola && (out_height_z == 16'd0))
    else $error("degenerate word with bad fields");

  // reset empties the pipe
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid right after reset");
endmodule

bind trackball_sphere_projection_top tbsp_check u_tbsp_check (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_s.valid),
  .out_ready       (out_s.ready),
  .out_height_z    (out_s.height_z),
  .out_on_hyperbola(out_s.on_hyperbola),
  .out_degenerate  (out_s.degenerate)
);
`default_nettype wire
